### rtl/brgc_pkg.sv
// Shared types and codes for the resource grant check block.
// Used by the channel interfaces, controller, datapath and top level.
package brgc_pkg;

   localparam int NUM_CUSTOMERS_DEF = 8;
   localparam int NUM_RESOURCES_DEF = 4;
   localparam int AMOUNT_WIDTH_DEF = 16;
   localparam int AMOUNT_FIELDS = 4;
   localparam int FIELD_WIDTH = 16;

   typedef logic [1:0] action_type;
   localparam action_type ACT_LOAD_AVAIL = 2'd0;
   localparam action_type ACT_LOAD_MAX = 2'd1;
   localparam action_type ACT_BORROW = 2'd2;
   localparam action_type ACT_REPAY = 2'd3;

   typedef logic [1:0] csr_addr_type;
   localparam csr_addr_type CSR_CUSTOMERS = 2'd0;
   localparam csr_addr_type CSR_RESOURCES = 2'd1;

   localparam logic [3:0] RESET_CUSTOMERS = 4'd8;
   localparam logic [2:0] RESET_RESOURCES = 3'd4;

   typedef enum logic [2:0] {
      STAT_OK,
      STAT_OVER_NEED,
      STAT_OVER_AVAIL,
      STAT_UNSAFE,
      STAT_OVER_ALLOC,
      STAT_BAD_CUSTOMER
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_RD,
      ST_ROW_CHK,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_COMMIT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic       take;
      logic       capture;
      logic       load_avail;
      logic       row_read;
      logic       addr_walk;
      logic       write_max;
      logic       commit_repay;
      logic       commit_borrow;
      logic       walk_init;
      logic       walk_step;
      logic       rsp_load;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic       req_valid;
      action_type action;
      logic       bad_customer;
      logic       over_need;
      logic       over_avail;
      logic       over_alloc;
      logic       row_fits;
      logic       rsp_free;
   } stat_type;

endpackage

### rtl/brgc_if.sv
// Channel interfaces: request, response and register write.
// Depends on brgc_pkg.
interface brgc_req_if;
   import brgc_pkg::*;
   logic                   valid;
   logic                   ready;
   action_type             action;
   logic [2:0]             customer;
   logic [FIELD_WIDTH-1:0] amount_0;
   logic [FIELD_WIDTH-1:0] amount_1;
   logic [FIELD_WIDTH-1:0] amount_2;
   logic [FIELD_WIDTH-1:0] amount_3;
   modport source (output valid, action, customer, amount_0, amount_1, amount_2, amount_3,
                   input ready);
   modport sink (input valid, action, customer, amount_0, amount_1, amount_2, amount_3,
                 output ready);
endinterface

interface brgc_rsp_if;
   import brgc_pkg::*;
   logic       valid;
   logic       ready;
   logic       approved;
   logic [2:0] status;
   modport source (output valid, approved, status, input ready);
   modport sink (input valid, approved, status, output ready);
endinterface

interface brgc_csr_if;
   import brgc_pkg::*;
   logic         valid;
   logic         ready;
   csr_addr_type addr;
   logic [7:0]   data;
   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

### rtl/bankers_resource_grant_check.sv
// Banker's algorithm grant check: top level joining controller and datapath.
// Depends on brgc_pkg, brgc_if, brgc_ctrl and brgc_dp.
//
// req_bus carries one transaction per item: action, customer and four amounts.
// rsp_bus returns one transaction per item: approved and a status code.
// csr_bus writes active_customers (index 0) and active_resources (index 1);
// it is always ready. The user must write it only while the block is idle;
// the block itself does not enforce this. One item is in work at a time. Loads
// of the available vector and refusals for a bad customer answer without a row
// read; maximum loads, repays, and borrows refused on need or availability
// answer after one row read. A borrow that reaches the safety walk reads the
// active customer rows one at a time through the single read port of the row
// memory and repeats passes until all finish or a pass finishes none.
// A finished result sits in the output register; the next item is taken
// while it waits, and a second result holds until the receiver takes the first.
// Reset clears the available vector and all rows, and sets the registers to
// 8 customers and 4 resource kinds. No clearing pass follows reset.
module bankers_resource_grant_check #(
   parameter int NUM_CUSTOMERS = brgc_pkg::NUM_CUSTOMERS_DEF,
   parameter int NUM_RESOURCES = brgc_pkg::NUM_RESOURCES_DEF,
   parameter int AMOUNT_WIDTH = brgc_pkg::AMOUNT_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   brgc_req_if.sink   req_bus,
   brgc_rsp_if.source rsp_bus,
   brgc_csr_if.sink   csr_bus
);
   import brgc_pkg::*;

   localparam int CIW = $clog2(NUM_CUSTOMERS > 1 ? NUM_CUSTOMERS : 2);
   localparam int CNTW = $clog2(NUM_CUSTOMERS + 1);

   cmd_type         cmd;
   stat_type        stat;
   logic [CIW-1:0]  walk_idx;
   logic [CNTW-1:0] used_customers;

   brgc_ctrl #(
      .NUM_CUSTOMERS(NUM_CUSTOMERS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .stat(stat),
      .used_customers(used_customers),
      .cmd(cmd),
      .walk_idx(walk_idx)
   );

   brgc_dp #(
      .NUM_CUSTOMERS(NUM_CUSTOMERS),
      .NUM_RESOURCES(NUM_RESOURCES),
      .AMOUNT_WIDTH(AMOUNT_WIDTH)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus),
      .cmd(cmd),
      .walk_idx(walk_idx),
      .stat(stat),
      .used_customers(used_customers)
   );

endmodule

### rtl/brgc_ctrl.sv
// Sequencer for the grant check: item flow, safety walk passes, result hand-off.
// Depends on brgc_pkg; drives the datapath through cmd_type.
module brgc_ctrl #(
   parameter int NUM_CUSTOMERS = brgc_pkg::NUM_CUSTOMERS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  brgc_pkg::stat_type                 stat,
   input  logic [$clog2(NUM_CUSTOMERS+1)-1:0] used_customers,
   output brgc_pkg::cmd_type                  cmd,
   output logic [$clog2(NUM_CUSTOMERS > 1 ? NUM_CUSTOMERS : 2)-1:0] walk_idx
);
   import brgc_pkg::*;

   localparam int CIW = $clog2(NUM_CUSTOMERS > 1 ? NUM_CUSTOMERS : 2);
   localparam int CNTW = $clog2(NUM_CUSTOMERS + 1);

   state_type              state_ff, state_in;
   logic [CIW-1:0]         idx_ff, idx_in;
   logic [NUM_CUSTOMERS-1:0] done_ff, done_in;
   logic                   prog_ff, prog_in;
   logic [CNTW-1:0]        fin_ff, fin_in;
   status_type             code_ff, code_in;
   logic                   adv;
   logic                   last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         done_ff <= '0;
         prog_ff <= 1'b0;
         fin_ff <= '0;
         code_ff <= STAT_OK;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         done_ff <= done_in;
         prog_ff <= prog_in;
         fin_ff <= fin_in;
         code_ff <= code_in;
      end
   end

   assign walk_idx = idx_ff;
   assign last = (CNTW'(idx_ff) == CNTW'(used_customers - 1'b1));

   always_comb begin
      cmd = '0;
      cmd.rsp_status = code_ff;
      state_in = state_ff;
      idx_in = idx_ff;
      done_in = done_ff;
      prog_in = prog_ff;
      fin_in = fin_ff;
      code_in = code_ff;
      adv = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (stat.req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_ROW_RD;
            end
         end
         ST_ROW_RD: begin
            if (stat.action == ACT_LOAD_AVAIL) begin
               cmd.load_avail = 1'b1;
               code_in = STAT_OK;
               state_in = ST_RESULT;
            end else if (stat.bad_customer) begin
               code_in = STAT_BAD_CUSTOMER;
               state_in = ST_RESULT;
            end else begin
               cmd.row_read = 1'b1;
               state_in = ST_ROW_CHK;
            end
         end
         ST_ROW_CHK: begin
            state_in = ST_RESULT;
            code_in = STAT_OK;
            case (stat.action)
               ACT_LOAD_MAX: begin
                  cmd.write_max = 1'b1;
               end
               ACT_BORROW: begin
                  if (stat.over_need) begin
                     code_in = STAT_OVER_NEED;
                  end else if (stat.over_avail) begin
                     code_in = STAT_OVER_AVAIL;
                  end else begin
                     cmd.walk_init = 1'b1;
                     idx_in = '0;
                     done_in = '0;
                     prog_in = 1'b0;
                     fin_in = '0;
                     state_in = ST_WALK_RD;
                  end
               end
               ACT_REPAY: begin
                  if (stat.over_alloc) begin
                     code_in = STAT_OVER_ALLOC;
                  end else begin
                     cmd.commit_repay = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_WALK_RD: begin
            if (done_ff[idx_ff]) begin
               adv = 1'b1;
            end else begin
               cmd.row_read = 1'b1;
               cmd.addr_walk = 1'b1;
               state_in = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            cmd.walk_step = 1'b1;
            if (stat.row_fits) begin
               done_in[idx_ff] = 1'b1;
               fin_in = fin_ff + 1'b1;
               prog_in = 1'b1;
            end
            adv = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit_borrow = 1'b1;
            code_in = STAT_OK;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // advance the walk: next row, or close the pass
      if (adv) begin
         if (last) begin
            if (fin_in == used_customers) begin
               state_in = ST_COMMIT;
            end else if (!prog_in) begin
               code_in = STAT_UNSAFE;
               state_in = ST_RESULT;
            end else begin
               idx_in = '0;
               prog_in = 1'b0;
               state_in = ST_WALK_RD;
            end
         end else begin
            idx_in = idx_ff + 1'b1;
            state_in = ST_WALK_RD;
         end
      end
   end

endmodule

### rtl/brgc_dp.sv
// Datapath: register file, available vector, row memory, walk accumulators, output register.
// Depends on brgc_pkg and the channel interfaces in brgc_if.
module brgc_dp #(
   parameter int NUM_CUSTOMERS = brgc_pkg::NUM_CUSTOMERS_DEF,
   parameter int NUM_RESOURCES = brgc_pkg::NUM_RESOURCES_DEF,
   parameter int AMOUNT_WIDTH = brgc_pkg::AMOUNT_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   brgc_req_if.sink                           req_bus,
   brgc_rsp_if.source                         rsp_bus,
   brgc_csr_if.sink                           csr_bus,
   input  brgc_pkg::cmd_type                  cmd,
   input  logic [$clog2(NUM_CUSTOMERS > 1 ? NUM_CUSTOMERS : 2)-1:0] walk_idx,
   output brgc_pkg::stat_type                 stat,
   output logic [$clog2(NUM_CUSTOMERS+1)-1:0] used_customers
);
   import brgc_pkg::*;

   localparam int NC = NUM_CUSTOMERS;
   localparam int NR = NUM_RESOURCES;
   localparam int AW = AMOUNT_WIDTH;
   localparam int CIW = $clog2(NC > 1 ? NC : 2);
   localparam int CNTW = $clog2(NC + 1);
   localparam int RNTW = $clog2(NR + 1);
   localparam int WW = AW + $clog2(NC + 2);

   typedef logic [NR-1:0][AW-1:0] row_type;
   typedef logic [NR-1:0][WW-1:0] work_type;

   logic [3:0]      csr_cust_ff;
   logic [2:0]      csr_res_ff;
   logic [CNTW-1:0] nc;
   logic [RNTW-1:0] nr;
   logic [NR-1:0]   lane_on;

   logic [AMOUNT_FIELDS-1:0][FIELD_WIDTH-1:0] in_fields;
   row_type         amt_in;
   action_type      act_ff;
   logic [2:0]      item_cust_ff;
   row_type         amt_ff;
   logic [CIW-1:0]  c_idx;

   row_type         mem_max [NC];
   row_type         mem_alloc [NC];
   logic [NC-1:0]   row_valid_ff;
   logic [CIW-1:0]  rd_addr;
   row_type         rd_max_ff, rd_alloc_ff;
   logic            rd_hit_ff;
   logic            wr_en;
   row_type         wr_max, wr_alloc;

   row_type         avail_ff, avail_in;
   work_type        work_ff, work_in;
   row_type         save_max_ff, save_alloc_ff;
   row_type         held, need;
   logic [AW:0]     sum;

   logic            fits, over_need, over_avail, over_alloc;
   logic            rsp_valid_ff;
   logic            approved_ff;
   status_type      status_ff;

   // register file
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_cust_ff <= RESET_CUSTOMERS;
         csr_res_ff <= RESET_RESOURCES;
      end else if (csr_bus.valid) begin
         case (csr_bus.addr)
            CSR_CUSTOMERS: csr_cust_ff <= csr_bus.data[3:0];
            CSR_RESOURCES: csr_res_ff <= csr_bus.data[2:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (csr_cust_ff == '0) begin
         nc = CNTW'(1);
      end else if (32'(csr_cust_ff) > NC) begin
         nc = CNTW'(NC);
      end else begin
         nc = CNTW'(csr_cust_ff);
      end
      if (csr_res_ff == '0) begin
         nr = RNTW'(1);
      end else if (32'(csr_res_ff) > NR) begin
         nr = RNTW'(NR);
      end else begin
         nr = RNTW'(csr_res_ff);
      end
   end
   assign used_customers = nc;

   // request capture
   assign req_bus.ready = cmd.take;
   assign in_fields = {req_bus.amount_3, req_bus.amount_2, req_bus.amount_1, req_bus.amount_0};

   for (genvar g = 0; g < NR; g++) begin : g_lane
      assign lane_on[g] = (32'(nr) > g);
      if (g < AMOUNT_FIELDS) begin : g_fld
         assign amt_in[g] = AW'(in_fields[g]);
      end else begin : g_zero
         assign amt_in[g] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_bus.action;
         item_cust_ff <= req_bus.customer;
         amt_ff <= amt_in;
      end
   end
   assign c_idx = CIW'(item_cust_ff);

   // row memory: maximum and allocation rows share one address
   assign rd_addr = cmd.addr_walk ? walk_idx : c_idx;

   always_ff @(posedge clock) begin
      if (cmd.row_read) begin
         rd_max_ff <= row_valid_ff[rd_addr] ? mem_max[rd_addr] : '0;
         rd_alloc_ff <= row_valid_ff[rd_addr] ? mem_alloc[rd_addr] : '0;
         rd_hit_ff <= (rd_addr == c_idx);
      end
      if (wr_en) begin
         mem_max[c_idx] <= wr_max;
         mem_alloc[c_idx] <= wr_alloc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[c_idx] <= 1'b1;
      end
   end

   always_comb begin
      wr_en = cmd.write_max | cmd.commit_repay | cmd.commit_borrow;
      wr_max = rd_max_ff;
      wr_alloc = rd_alloc_ff;
      avail_in = avail_ff;
      for (int r = 0; r < NR; r++) begin
         sum = {1'b0, avail_ff[r]} + {1'b0, amt_ff[r]};
         if (cmd.write_max) begin
            wr_alloc[r] = '0;
            if (lane_on[r]) wr_max[r] = amt_ff[r];
         end
         if (cmd.commit_borrow) begin
            wr_max[r] = save_max_ff[r];
            wr_alloc[r] = lane_on[r] ? save_alloc_ff[r] + amt_ff[r] : save_alloc_ff[r];
         end
         if (lane_on[r]) begin
            if (cmd.commit_repay) begin
               wr_alloc[r] = rd_alloc_ff[r] - amt_ff[r];
               avail_in[r] = sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
            end
            if (cmd.load_avail) avail_in[r] = amt_ff[r];
            if (cmd.commit_borrow) avail_in[r] = avail_ff[r] - amt_ff[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '0;
      end else begin
         avail_ff <= avail_in;
      end
   end

   // admission checks and safety walk
   always_comb begin
      over_need = 1'b0;
      over_avail = 1'b0;
      over_alloc = 1'b0;
      fits = 1'b1;
      work_in = work_ff;
      for (int r = 0; r < NR; r++) begin
         held[r] = rd_alloc_ff[r] + (rd_hit_ff ? amt_ff[r] : '0);
         need[r] = rd_max_ff[r] - held[r];
         if (lane_on[r]) begin
            if (amt_ff[r] > rd_max_ff[r] - rd_alloc_ff[r]) over_need = 1'b1;
            if (amt_ff[r] > avail_ff[r]) over_avail = 1'b1;
            if (amt_ff[r] > rd_alloc_ff[r]) over_alloc = 1'b1;
            if (WW'(need[r]) > work_ff[r]) fits = 1'b0;
         end
      end
      for (int r = 0; r < NR; r++) begin
         if (cmd.walk_init) begin
            work_in[r] = WW'(avail_ff[r]) - WW'(amt_ff[r]);
         end else if (cmd.walk_step && fits) begin
            work_in[r] = work_ff[r] + WW'(held[r]);
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (cmd.walk_init) begin
         save_max_ff <= rd_max_ff;
         save_alloc_ff <= rd_alloc_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         approved_ff <= (cmd.rsp_status == STAT_OK);
         status_ff <= cmd.rsp_status;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.approved = approved_ff;
   assign rsp_bus.status = status_ff;

   always_comb begin
      stat.req_valid = req_bus.valid;
      stat.action = act_ff;
      stat.bad_customer = (32'(item_cust_ff) >= 32'(nc));
      stat.over_need = over_need;
      stat.over_avail = over_avail;
      stat.over_alloc = over_alloc;
      stat.row_fits = fits;
      stat.rsp_free = !rsp_valid_ff || rsp_bus.ready;
   end

endmodule

### bench/brgc_grant_book.sv
// Scoreboard for the resource grant check: a banker's state copy and a queue of expected grants.
// Depends on brgc_pkg.
`timescale 1ns / 100ps
class brgc_grant_book;
   typedef struct packed {
      logic                       approved;
      brgc_pkg::status_type       status;
   } grant_type;

   logic [3:0]  customers_reg;
   logic [2:0]  resources_reg;
   logic [16:0] avail [4];
   logic [16:0] maxrow [8][4];
   logic [16:0] held [8][4];
   grant_type   pending [$];
   int          fail_count;

   function new();
      customers_reg = brgc_pkg::RESET_CUSTOMERS;
      resources_reg = brgc_pkg::RESET_RESOURCES;
      foreach (avail[r]) avail[r] = '0;
      foreach (maxrow[i, r]) begin
         maxrow[i][r] = '0;
         held[i][r] = '0;
      end
      fail_count = 0;
   endfunction

   function void write_reg(brgc_pkg::csr_addr_type addr, logic [7:0] data);
      if (addr == brgc_pkg::CSR_CUSTOMERS) customers_reg = data[3:0];
      else if (addr == brgc_pkg::CSR_RESOURCES) resources_reg = data[2:0];
   endfunction

   function int used_customers();
      if (customers_reg < 1) return 1;
      if (customers_reg > 8) return 8;
      return customers_reg;
   endfunction

   function int used_resources();
      if (resources_reg < 1) return 1;
      if (resources_reg > 4) return 4;
      return resources_reg;
   endfunction

   function bit safe_after(int c, logic [15:0] amt [4], int nc, int nr);
      longint work [4];
      longint hold [8][4];
      bit     done [8];
      int     finished;
      bit     progress;
      bit     fits;
      finished = 0;
      foreach (hold[i, r]) hold[i][r] = held[i][r];
      foreach (done[i]) done[i] = 1'b0;
      for (int r = 0; r < nr; r++) begin
         work[r] = avail[r] - amt[r];
         hold[c][r] += amt[r];
      end
      progress = 1'b1;
      while (progress) begin
         progress = 1'b0;
         for (int i = 0; i < nc; i++) begin
            if (!done[i]) begin
               fits = 1'b1;
               for (int r = 0; r < nr; r++)
                  if (maxrow[i][r] - hold[i][r] > work[r]) fits = 1'b0;
               if (fits) begin
                  for (int r = 0; r < nr; r++) work[r] += hold[i][r];
                  done[i] = 1'b1;
                  finished++;
                  progress = 1'b1;
               end
            end
         end
      end
      return finished == nc;
   endfunction

   function void note_request(brgc_pkg::action_type act, int c, logic [15:0] amt [4]);
      grant_type g;
      int        nc;
      int        nr;
      bit        over_need;
      bit        over_avail;
      logic [16:0] sum;
      nc = used_customers();
      nr = used_resources();
      g.approved = 1'b1;
      g.status = brgc_pkg::STAT_OK;
      over_need = 1'b0;
      over_avail = 1'b0;
      if (act == brgc_pkg::ACT_LOAD_AVAIL) begin
         for (int r = 0; r < nr; r++) avail[r] = 17'(amt[r]);
      end else if (c >= nc) begin
         g = {1'b0, brgc_pkg::STAT_BAD_CUSTOMER};
      end else if (act == brgc_pkg::ACT_LOAD_MAX) begin
         for (int r = 0; r < nr; r++) maxrow[c][r] = 17'(amt[r]);
         for (int r = 0; r < 4; r++) held[c][r] = '0;
      end else if (act == brgc_pkg::ACT_BORROW) begin
         for (int r = 0; r < nr; r++) begin
            if (17'(amt[r]) > maxrow[c][r] - held[c][r]) over_need = 1'b1;
            if (17'(amt[r]) > avail[r]) over_avail = 1'b1;
         end
         if (over_need) g = {1'b0, brgc_pkg::STAT_OVER_NEED};
         else if (over_avail) g = {1'b0, brgc_pkg::STAT_OVER_AVAIL};
         else if (!safe_after(c, amt, nc, nr)) g = {1'b0, brgc_pkg::STAT_UNSAFE};
         else
            for (int r = 0; r < nr; r++) begin
               avail[r] = avail[r] - 17'(amt[r]);
               held[c][r] = held[c][r] + 17'(amt[r]);
            end
      end else begin
         for (int r = 0; r < nr; r++)
            if (17'(amt[r]) > held[c][r]) over_need = 1'b1;
         if (over_need) g = {1'b0, brgc_pkg::STAT_OVER_ALLOC};
         else
            for (int r = 0; r < nr; r++) begin
               sum = avail[r] + 17'(amt[r]);
               avail[r] = (sum > 17'h0ffff) ? 17'h0ffff : sum;
               held[c][r] = held[c][r] - 17'(amt[r]);
            end
      end
      pending.push_back(g);
   endfunction

   function void report(string what);
      $display("mismatch: %s", what);
      fail_count++;
   endfunction

   function void check_grant(logic approved, logic [2:0] status);
      grant_type g;
      if (pending.size() == 0) begin
         report($sformatf("unexpected response approved=%0d status=%0d", approved, status));
         return;
      end
      g = pending.pop_front();
      if (approved !== g.approved)
         report($sformatf("approved %0d, expected %0d", approved, g.approved));
      if (status !== g.status)
         report($sformatf("status %0d, expected %0d", status, g.status));
   endfunction
endclass

### bench/brgc_bench_if.sv
// Bench settings: receiver hold-off length and watchdog limit for the bench top.
// Depends on no other file; used by bench/tb.sv.
`timescale 1ns / 100ps
package brgc_bench_pkg;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 20000;
endpackage

### bench/tb.sv
// Top of the resource grant check bench: clock, reset, drivers, response sink and checks.
// Depends on brgc_pkg, brgc_if, brgc_bench_pkg, brgc_grant_book and the block.
`timescale 1ns / 100ps
module tb;
   import brgc_pkg::*;

   logic clock = 0;
   logic reset = 1;
   brgc_req_if req_bus ();
   brgc_rsp_if rsp_bus ();
   brgc_csr_if csr_bus ();

   bankers_resource_grant_check dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   brgc_grant_book book = new();
   bit  calm = 0;
   bit  hold_off = 0;
   int  quiet = 0;
   logic [15:0] amt [4];

   always #10 clock = ~clock;

   initial begin
      req_bus.valid = 0;
      req_bus.action = ACT_LOAD_AVAIL;
      req_bus.customer = 0;
      req_bus.amount_0 = 0;
      req_bus.amount_1 = 0;
      req_bus.amount_2 = 0;
      req_bus.amount_3 = 0;
      rsp_bus.ready = 0;
      csr_bus.valid = 0;
      csr_bus.addr = CSR_CUSTOMERS;
      csr_bus.data = 0;
   end

   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready) book.check_grant(rsp_bus.approved, rsp_bus.status);
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= brgc_bench_pkg::WATCHDOG_LIMIT) begin
         $display("bankers_resource_grant_check regression: fail");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_bus.ready <= 0;
            repeat (brgc_bench_pkg::HOLD_OFF_CYCLES) @(posedge clock);
            hold_off = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 9);
            rsp_bus.ready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1;
            @(posedge clock);
         end
      end
   end

   task automatic write_reg(csr_addr_type addr, logic [7:0] data);
      csr_bus.valid <= 1;
      csr_bus.addr <= addr;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      book.write_reg(addr, data);
      csr_bus.valid <= 0;
      @(posedge clock);
   endtask

   task automatic send(action_type act, logic [2:0] c, logic [15:0] a [4]);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.action <= act;
      req_bus.customer <= c;
      req_bus.amount_0 <= a[0];
      req_bus.amount_1 <= a[1];
      req_bus.amount_2 <= a[2];
      req_bus.amount_3 <= a[3];
      do @(posedge clock); while (!req_bus.ready);
      book.note_request(act, c, a);
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      while (book.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic fill(int lo, int hi);
      foreach (amt[r]) amt[r] = 16'($urandom_range(lo, hi));
   endtask

   // mostly well-formed traffic: loads of max and available, borrows up to one past need, repays up to one past held
   task automatic random_phase(int count, int span);
      action_type act;
      int c;
      int nc;
      nc = book.used_customers();
      for (int k = 0; k < count; k++) begin
         c = $urandom_range(0, 7);
         case ($urandom_range(0, 19))
            0: begin
               act = ACT_LOAD_AVAIL;
               fill(0, span * 3);
            end
            1, 2: begin
               act = ACT_LOAD_MAX;
               fill(0, span);
            end
            3: begin
               act = 2'($urandom_range(0, 3));
               foreach (amt[r]) amt[r] = 16'($urandom);
            end
            4, 5, 6, 7, 8, 9, 10, 11: begin
               act = ACT_BORROW;
               c = $urandom_range(0, nc - 1);
               foreach (amt[r])
                  amt[r] = 16'($urandom_range(0, book.maxrow[c][r] - book.held[c][r] + 1));
            end
            default: begin
               act = ACT_REPAY;
               c = $urandom_range(0, nc - 1);
               foreach (amt[r]) amt[r] = 16'($urandom_range(0, book.held[c][r] + 1));
            end
         endcase
         send(act, 3'(c), amt);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, every action, each refusal path
      foreach (amt[r]) amt[r] = 16'hffff;
      send(ACT_LOAD_AVAIL, 3'd7, amt);
      send(ACT_LOAD_MAX, 3'd0, amt);
      send(ACT_LOAD_MAX, 3'd7, amt);
      foreach (amt[r]) amt[r] = 16'h5555;
      send(ACT_BORROW, 3'd0, amt);
      foreach (amt[r]) amt[r] = 16'hffff;
      send(ACT_BORROW, 3'd0, amt);
      send(ACT_REPAY, 3'd0, amt);
      foreach (amt[r]) amt[r] = 16'h5555;
      send(ACT_REPAY, 3'd0, amt);
      send(ACT_REPAY, 3'd0, amt);
      foreach (amt[r]) amt[r] = 16'haaaa;
      send(ACT_LOAD_AVAIL, 3'd0, amt);
      send(ACT_BORROW, 3'd7, amt);
      foreach (amt[r]) amt[r] = 16'h0000;
      send(ACT_LOAD_MAX, 3'd1, amt);
      send(ACT_BORROW, 3'd1, amt);
      send(ACT_REPAY, 3'd1, amt);
      drain();

      write_reg(CSR_CUSTOMERS, 8'd2);
      write_reg(CSR_RESOURCES, 8'd1);
      foreach (amt[r]) amt[r] = 16'd10;
      send(ACT_LOAD_AVAIL, 3'd0, amt);
      send(ACT_LOAD_MAX, 3'd0, amt);
      send(ACT_LOAD_MAX, 3'd1, amt);
      send(ACT_LOAD_MAX, 3'd2, amt);
      foreach (amt[r]) amt[r] = 16'd6;
      send(ACT_BORROW, 3'd0, amt);
      send(ACT_BORROW, 3'd1, amt);
      send(ACT_REPAY, 3'd5, amt);
      foreach (amt[r]) amt[r] = 16'd4;
      send(ACT_BORROW, 3'd1, amt);
      drain();

      // configuration sweep, out-of-range values included
      write_reg(CSR_CUSTOMERS, 8'hff);
      write_reg(CSR_RESOURCES, 8'hff);
      random_phase(80, 40);
      drain();
      write_reg(CSR_CUSTOMERS, 8'd0);
      write_reg(CSR_RESOURCES, 8'd0);
      random_phase(60, 20);
      drain();
      write_reg(CSR_CUSTOMERS, 8'd1);
      write_reg(CSR_RESOURCES, 8'd4);
      random_phase(60, 20);
      drain();
      write_reg(CSR_CUSTOMERS, 8'd8);
      write_reg(CSR_RESOURCES, 8'd3);
      hold_off = 1;
      random_phase(150, 12);
      drain();
      write_reg(CSR_CUSTOMERS, 8'd5);
      write_reg(CSR_RESOURCES, 8'd2);
      random_phase(150, 8);
      drain();
      write_reg(CSR_CUSTOMERS, 8'd8);
      write_reg(CSR_RESOURCES, 8'd4);
      random_phase(150, 65535);
      drain();
      calm = 1;
      random_phase(80, 10);
      drain();

      if (book.fail_count == 0)
         $display("bankers_resource_grant_check regression: pass");
      else
         $display("bankers_resource_grant_check regression: fail");
      $finish;
   end
endmodule

### sim.f
rtl/brgc_pkg.sv
rtl/brgc_if.sv
rtl/brgc_ctrl.sv
rtl/brgc_dp.sv
rtl/bankers_resource_grant_check.sv
bench/brgc_grant_book.sv
bench/brgc_bench_if.sv
bench/tb.sv
